[design/decimal_length_prefix_deframer_macros.svh]
// ----------------------------------------------------------------------------
// decimal_length_prefix_deframer_macros.svh
// Assertion macros shared by the deframer modules.
// ----------------------------------------------------------------------------
`ifndef DECIMAL_LENGTH_PREFIX_DEFRAMER_MACROS_SVH
`define DECIMAL_LENGTH_PREFIX_DEFRAMER_MACROS_SVH

// Check a property on every clock edge outside reset.
`define DLPD_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error(msg);

// Check that a condition holds in the cycle after a trigger.
`define DLPD_ASSERT_NEXT(label, trig, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (trig) |=> (cons)) else $error(msg);

`endif

[design/dlpd_pkg.sv]
// ----------------------------------------------------------------------------
// dlpd_pkg
// Types, constants and codes of the decimal length-prefix deframer.
// ----------------------------------------------------------------------------
package dlpd_pkg;

    localparam int MAX_HEADER_DIGITS = 6;
    localparam int HDR_POS_W         = $clog2(MAX_HEADER_DIGITS + 1);
    localparam int LEN_W             = 20;
    localparam logic [LEN_W-1:0] LEN_MAX   = {LEN_W{1'b1}};
    localparam logic [LEN_W-1:0] LEN_RESET = LEN_W'(999999);

    localparam logic [7:0] CH_NL    = 8'h0A;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_VT    = 8'h0B;
    localparam logic [7:0] CH_FF    = 8'h0C;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;

    typedef enum logic [1:0] {
        PH_HEADER,
        PH_PAYLOAD,
        PH_ERROR
    } t_phase;

    typedef enum logic [1:0] {
        SUB_SKIP,
        SUB_SIGNED,
        SUB_DIGITS,
        SUB_DONE
    } t_sub;

    typedef enum logic [1:0] {
        ST_PAYLOAD,
        ST_NO_NEWLINE,
        ST_BAD_LENGTH,
        ST_TOO_LONG
    } t_status;

    typedef struct packed {
        logic [7:0]       payload_byte;
        logic             first_of_frame;
        logic             last_of_frame;
        logic [LEN_W-1:0] frame_length;
        t_status          status;
    } t_result;

endpackage

[design/dlpd_core.sv]
// ----------------------------------------------------------------------------
// dlpd_core
// Frame state, header parser and per-byte result logic of the deframer.
// ----------------------------------------------------------------------------
`include "decimal_length_prefix_deframer_macros.svh"

module dlpd_core (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_take,
    input  logic [7:0]                       i_data_byte,
    input  logic                             i_cfg_we,
    input  logic [dlpd_pkg::LEN_W-1:0]       i_cfg_max_len,
    output logic                             o_res_valid,
    output dlpd_pkg::t_result                o_res
);

    dlpd_pkg::t_phase                    r_phase,     n_phase;
    dlpd_pkg::t_sub                      r_sub,       n_sub;
    dlpd_pkg::t_status                   r_err,       n_err;
    logic [dlpd_pkg::HDR_POS_W-1:0]      r_pos,       n_pos;
    logic [dlpd_pkg::LEN_W-1:0]          r_acc,       n_acc;
    logic                                r_neg,       n_neg;
    logic [dlpd_pkg::LEN_W-1:0]          r_remaining, n_remaining;
    logic [dlpd_pkg::LEN_W-1:0]          r_announced, n_announced;
    logic [dlpd_pkg::LEN_W-1:0]          r_max_len;

    logic                                is_nl;
    logic                                is_digit;
    logic                                is_space;
    logic                                is_sign;
    logic                                hdr_full;
    logic                                len_bad;
    logic                                len_big;
    logic                                pl_first;
    logic                                pl_last;
    logic [dlpd_pkg::LEN_W+3:0]          acc_prod;
    logic [dlpd_pkg::LEN_W-1:0]          acc_digit;

    assign is_nl    = (i_data_byte == dlpd_pkg::CH_NL);
    assign is_digit = (i_data_byte >= dlpd_pkg::CH_ZERO) && (i_data_byte <= dlpd_pkg::CH_NINE);
    assign is_space = (i_data_byte == dlpd_pkg::CH_SPACE) || (i_data_byte == dlpd_pkg::CH_TAB)
                   || (i_data_byte == dlpd_pkg::CH_VT) || (i_data_byte == dlpd_pkg::CH_FF)
                   || (i_data_byte == dlpd_pkg::CH_CR);
    assign is_sign  = (i_data_byte == dlpd_pkg::CH_PLUS) || (i_data_byte == dlpd_pkg::CH_MINUS);
    assign hdr_full = (r_pos >= dlpd_pkg::HDR_POS_W'(dlpd_pkg::MAX_HEADER_DIGITS));
    assign len_bad  = (r_acc == '0) || r_neg;
    assign len_big  = (r_acc > r_max_len);
    assign pl_first = (r_remaining == r_announced);
    assign pl_last  = (r_remaining <= dlpd_pkg::LEN_W'(1));

    // acc * 10 + digit, saturated
    assign acc_prod  = {1'b0, r_acc, 3'b000} + {3'b000, r_acc, 1'b0}
                     + {(dlpd_pkg::LEN_W)'(0), i_data_byte[3:0]};
    assign acc_digit = (acc_prod[dlpd_pkg::LEN_W+3:dlpd_pkg::LEN_W] != 4'd0)
                     ? dlpd_pkg::LEN_MAX : acc_prod[dlpd_pkg::LEN_W-1:0];

    always_comb begin
        n_phase     = r_phase;
        n_sub       = r_sub;
        n_err       = r_err;
        n_pos       = r_pos;
        n_acc       = r_acc;
        n_neg       = r_neg;
        n_remaining = r_remaining;
        n_announced = r_announced;
        if (i_take) begin
            unique case (r_phase)
                dlpd_pkg::PH_ERROR: begin
                end
                dlpd_pkg::PH_PAYLOAD: begin
                    if (pl_last) begin
                        n_phase     = dlpd_pkg::PH_HEADER;
                        n_remaining = '0;
                        n_sub       = dlpd_pkg::SUB_SKIP;
                        n_pos       = '0;
                        n_acc       = '0;
                        n_neg       = 1'b0;
                    end else begin
                        n_remaining = r_remaining - dlpd_pkg::LEN_W'(1);
                    end
                end
                dlpd_pkg::PH_HEADER: begin
                    if (is_nl) begin
                        if (len_bad) begin
                            n_phase     = dlpd_pkg::PH_ERROR;
                            n_err       = dlpd_pkg::ST_BAD_LENGTH;
                            n_announced = '0;
                        end else if (len_big) begin
                            n_phase     = dlpd_pkg::PH_ERROR;
                            n_err       = dlpd_pkg::ST_TOO_LONG;
                            n_announced = r_acc;
                        end else begin
                            n_phase     = dlpd_pkg::PH_PAYLOAD;
                            n_announced = r_acc;
                            n_remaining = r_acc;
                            n_sub       = dlpd_pkg::SUB_SKIP;
                            n_pos       = '0;
                            n_acc       = '0;
                            n_neg       = 1'b0;
                        end
                    end else if (hdr_full) begin
                        n_phase     = dlpd_pkg::PH_ERROR;
                        n_err       = dlpd_pkg::ST_NO_NEWLINE;
                        n_announced = '0;
                    end else begin
                        n_pos = r_pos + dlpd_pkg::HDR_POS_W'(1);
                        unique case (r_sub)
                            dlpd_pkg::SUB_SKIP: begin
                                if (is_space) begin
                                end else if (is_sign) begin
                                    n_neg = (i_data_byte == dlpd_pkg::CH_MINUS);
                                    n_sub = dlpd_pkg::SUB_SIGNED;
                                end else if (is_digit) begin
                                    n_acc = acc_digit;
                                    n_sub = dlpd_pkg::SUB_DIGITS;
                                end else begin
                                    n_sub = dlpd_pkg::SUB_DONE;
                                end
                            end
                            dlpd_pkg::SUB_SIGNED, dlpd_pkg::SUB_DIGITS: begin
                                if (is_digit) begin
                                    n_acc = acc_digit;
                                    n_sub = dlpd_pkg::SUB_DIGITS;
                                end else begin
                                    n_sub = dlpd_pkg::SUB_DONE;
                                end
                            end
                            default: begin
                            end
                        endcase
                    end
                end
                default: begin
                    n_phase = dlpd_pkg::PH_HEADER;
                end
            endcase
        end
    end

    always_comb begin
        o_res_valid         = 1'b0;
        o_res.payload_byte   = '0;
        o_res.first_of_frame = 1'b0;
        o_res.last_of_frame  = 1'b0;
        o_res.frame_length   = '0;
        o_res.status         = dlpd_pkg::ST_PAYLOAD;
        unique case (r_phase)
            dlpd_pkg::PH_ERROR: begin
                o_res_valid        = 1'b1;
                o_res.frame_length = r_announced;
                o_res.status       = r_err;
            end
            dlpd_pkg::PH_PAYLOAD: begin
                o_res_valid          = 1'b1;
                o_res.payload_byte   = i_data_byte;
                o_res.first_of_frame = pl_first;
                o_res.last_of_frame  = pl_last;
                o_res.frame_length   = r_announced;
            end
            dlpd_pkg::PH_HEADER: begin
                if (is_nl) begin
                    if (len_bad) begin
                        o_res_valid  = 1'b1;
                        o_res.status = dlpd_pkg::ST_BAD_LENGTH;
                    end else if (len_big) begin
                        o_res_valid        = 1'b1;
                        o_res.status       = dlpd_pkg::ST_TOO_LONG;
                        o_res.frame_length = r_acc;
                    end
                end else if (hdr_full) begin
                    o_res_valid  = 1'b1;
                    o_res.status = dlpd_pkg::ST_NO_NEWLINE;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= dlpd_pkg::PH_HEADER;
            r_sub       <= dlpd_pkg::SUB_SKIP;
            r_err       <= dlpd_pkg::ST_PAYLOAD;
            r_pos       <= '0;
            r_acc       <= '0;
            r_neg       <= 1'b0;
            r_remaining <= '0;
            r_announced <= '0;
            r_max_len   <= dlpd_pkg::LEN_RESET;
        end else begin
            r_phase     <= n_phase;
            r_sub       <= n_sub;
            r_err       <= n_err;
            r_pos       <= n_pos;
            r_acc       <= n_acc;
            r_neg       <= n_neg;
            r_remaining <= n_remaining;
            r_announced <= n_announced;
            if (i_cfg_we) begin
                r_max_len <= i_cfg_max_len;
            end
        end
    end

    `DLPD_ASSERT(a_payload_count, (r_phase != dlpd_pkg::PH_PAYLOAD) ||
        ((r_remaining != '0) && (r_remaining <= r_announced)),
        "payload count outside announced length")
    `DLPD_ASSERT(a_header_pos, (r_phase != dlpd_pkg::PH_HEADER) ||
        (r_pos <= dlpd_pkg::HDR_POS_W'(dlpd_pkg::MAX_HEADER_DIGITS)),
        "header position past limit")
    `DLPD_ASSERT_NEXT(a_error_sticky, r_phase == dlpd_pkg::PH_ERROR,
        (r_phase == dlpd_pkg::PH_ERROR) && $stable(r_err) && $stable(r_announced),
        "error state left or changed")

endmodule

[design/dlpd_skid.sv]
// ----------------------------------------------------------------------------
// dlpd_skid
// Two-entry result register: output stage plus skid stage.
// ----------------------------------------------------------------------------
`include "decimal_length_prefix_deframer_macros.svh"

module dlpd_skid (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  dlpd_pkg::t_result i_res,
    output logic              o_ready,
    output logic              o_valid,
    input  logic              i_ready,
    output dlpd_pkg::t_result o_res
);

    logic              r_out_valid;
    logic              r_skid_valid;
    dlpd_pkg::t_result r_out;
    dlpd_pkg::t_result r_skid;
    logic              pop;

    assign pop     = r_out_valid && i_ready;
    assign o_ready = !r_skid_valid;
    assign o_valid = r_out_valid;
    assign o_res   = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_skid_valid) begin
            if (pop) begin
                r_skid_valid <= 1'b0;
            end
        end else if (i_push) begin
            if (r_out_valid && !pop) begin
                r_skid_valid <= 1'b1;
            end else begin
                r_out_valid <= 1'b1;
            end
        end else if (pop) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_valid) begin
            if (pop) begin
                r_out <= r_skid;
            end
        end else if (i_push) begin
            if (r_out_valid && !pop) begin
                r_skid <= i_res;
            end else begin
                r_out <= i_res;
            end
        end
    end

    `DLPD_ASSERT(a_skid_implies_out, !r_skid_valid || r_out_valid,
        "skid stage full with output stage empty")
    `DLPD_ASSERT_NEXT(a_push_held, i_push && r_out_valid && !pop,
        r_skid_valid && r_out_valid, "stalled transfer not held")
    `DLPD_ASSERT_NEXT(a_skid_drain, r_skid_valid && pop,
        !r_skid_valid && r_out_valid, "skid stage not drained")

endmodule

[design/decimal_length_prefix_deframer.sv]
// ----------------------------------------------------------------------------
// decimal_length_prefix_deframer
// Takes one stream byte per cycle while input ready is high. Header bytes
// give no result, but for one that sets the sticky error; each payload byte,
// and each byte once the sticky error is set, gives one result, held in the
// two-entry result register. Input ready depends only on that register: it
// drops only while both the output stage and the skid stage hold a result, so
// a stalled output side costs no input cycle until two results are waiting.
// Configuration writes are taken in any cycle.
// ----------------------------------------------------------------------------
module decimal_length_prefix_deframer (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    output logic                       o_in_ready,
    input  logic [7:0]                 i_data_byte,
    output logic                       o_out_valid,
    input  logic                       i_out_ready,
    output logic [7:0]                 o_payload_byte,
    output logic                       o_first_of_frame,
    output logic                       o_last_of_frame,
    output logic [dlpd_pkg::LEN_W-1:0] o_frame_length,
    output logic [1:0]                 o_status,
    input  logic                       i_cfg_valid,
    output logic                       o_cfg_ready,
    input  logic [dlpd_pkg::LEN_W-1:0] i_cfg_max_payload_len
);

    logic              take;
    logic              res_valid;
    dlpd_pkg::t_result res;
    dlpd_pkg::t_result out_res;

    assign take        = i_in_valid && o_in_ready;
    assign o_cfg_ready = 1'b1;

    dlpd_core u_core (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_take        (take),
        .i_data_byte   (i_data_byte),
        .i_cfg_we      (i_cfg_valid),
        .i_cfg_max_len (i_cfg_max_payload_len),
        .o_res_valid   (res_valid),
        .o_res         (res)
    );

    dlpd_skid u_skid (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (take && res_valid),
        .i_res   (res),
        .o_ready (o_in_ready),
        .o_valid (o_out_valid),
        .i_ready (i_out_ready),
        .o_res   (out_res)
    );

    assign o_payload_byte   = out_res.payload_byte;
    assign o_first_of_frame = out_res.first_of_frame;
    assign o_last_of_frame  = out_res.last_of_frame;
    assign o_frame_length   = out_res.frame_length;
    assign o_status         = out_res.status;

endmodule
